// ----- rtl/gf2rk_pkg.sv -----
// ----------------------------------------------------------------------------
// gf2rk_pkg: shared types and constants for the GF(2) rank and kernel engine
// Field widths, configuration register indexes, reset values and the
// structs that travel between the engine's modules.
// ----------------------------------------------------------------------------
package gf2rk_pkg;

  localparam int ROW_W   = 64;  // bits in one matrix row
  localparam int COL_W   = 6;   // column index
  localparam int RANK_W  = 7;   // rank and column count, 0..64
  localparam int CFG_W   = 64;  // widest configuration register
  localparam int OUT_TDATA_W = 80;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE          = 2'd0,
    CFG_COLUMN_COUNT  = 2'd1,
    CFG_BLOCK_END     = 2'd2,
    CFG_WITNESS_START = 2'd3
  } cfg_idx_t;

  localparam logic MODE_PROFILE = 1'b0;
  localparam logic MODE_WITNESS = 1'b1;

  localparam logic [RANK_W-1:0] RST_COLUMN_COUNT = 7'd64;

  typedef struct packed {
    logic              mode;
    logic [RANK_W-1:0] column_count;
    logic [ROW_W-1:0]  block_end_mask;
    logic [COL_W-1:0]  witness_start;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_index;
    logic [RANK_W-1:0] rank_value;
    logic              found;
    logic [ROW_W-1:0]  kernel_mask;
    logic              overflow;
    logic              last;
  } result_t;

endpackage

// ----- rtl/gf2_rank_and_kernel_engine.sv -----
// ----------------------------------------------------------------------------
// gf2_rank_and_kernel_engine: GF(2) rank profile and kernel witness engine
// Rows of a bit matrix stream in one per word and land in a row RAM. The
// word with tlast set starts Gaussian elimination over the columns in use.
// Profile mode (mode 0) does forward elimination and reports the running rank after
// every column marked in block_end_mask, or once after the last column if none
// is marked. Witness mode (mode 1) does full Gauss-Jordan reduction and reports
// the first non-pivot column at or after witness_start with its kernel vector.
// ----------------------------------------------------------------------------
// Rate: a row word is taken every cycle while rows are loading. After the
// last row the input stalls while the run executes out of the row RAM, one
// row read per cycle through a read-modify-write loop: each column sweeps
// the rows from the current rank up in profile mode and every stored row
// in witness mode; witness mode then reads back the pivot rows for the
// kernel vector. Each result waits for the output register, so a stalled
// m_axis side stretches the run. Rows beyond MAX_ROWS are dropped and
// flagged in every result of that run. Configuration is written through
// cfg_we/cfg_index/cfg_data with no wait; write it only between runs.
// ----------------------------------------------------------------------------
module gf2_rank_and_kernel_engine #(
  parameter int MAX_ROWS = gf2rk_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gf2rk_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [gf2rk_pkg::CFG_W-1:0]       cfg_data,
  // row input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gf2rk_pkg::ROW_W-1:0]       s_axis_tdata,   // [63:0] row_bits
  input  logic                              s_axis_tlast,   // last_row
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gf2rk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] column_index,
                                                            // [12:6] rank_value,
                                                            // [76:13] kernel_mask,
                                                            // [77] overflow, [79:78] zero
  output logic [0:0]                        m_axis_tuser,   // [0] found
  output logic                              m_axis_tlast    // last
);

  import gf2rk_pkg::*;

  cfg_t    cfg;
  result_t core_res, out_res;
  logic    core_res_valid, core_res_ready;

  // Configuration registers: written on any cycle that cfg_we is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_PROFILE;
      cfg.column_count   <= RST_COLUMN_COUNT;
      cfg.block_end_mask <= '0;
      cfg.witness_start  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:          cfg.mode           <= cfg_data[0];
        CFG_COLUMN_COUNT:  cfg.column_count   <= cfg_data[RANK_W-1:0];
        CFG_BLOCK_END:     cfg.block_end_mask <= cfg_data[ROW_W-1:0];
        CFG_WITNESS_START: cfg.witness_start  <= cfg_data[COL_W-1:0];
        default:           cfg.mode           <= cfg.mode;
      endcase
    end
  end

  // Row store, elimination and kernel readback.
  gf2rk_core #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .row_valid (s_axis_tvalid),
    .row_ready (s_axis_tready),
    .row_bits  (s_axis_tdata),
    .last_row  (s_axis_tlast),
    .res_valid (core_res_valid),
    .res       (core_res),
    .res_ready (core_res_ready)
  );

  // Output register: hold a result while the core moves on.
  gf2rk_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (core_res_valid),
    .res       (core_res),
    .res_ready (core_res_ready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out_res.overflow, out_res.kernel_mask,
                         out_res.rank_value, out_res.column_index};
  assign m_axis_tuser = out_res.found;
  assign m_axis_tlast = out_res.last;

endmodule

// ----- rtl/gf2rk_ram.sv -----
// ----------------------------------------------------------------------------
// gf2rk_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gf2rk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gf2rk_out.sv -----
// ----------------------------------------------------------------------------
// gf2rk_out: result output register
// Holds one finished result for the downstream side; refills in the cycle
// that the held word is taken.
// ----------------------------------------------------------------------------
module gf2rk_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  gf2rk_pkg::result_t res,
  output logic               res_ready,
  output logic               out_valid,
  output gf2rk_pkg::result_t out_res,
  input  logic               out_ready
);

  import gf2rk_pkg::*;

  result_t held;
  logic    held_valid;

  assign res_ready = !held_valid || out_ready;
  assign out_valid = held_valid;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (res_ready) begin
      held_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

endmodule

// ----- rtl/gf2rk_core.sv -----
// ----------------------------------------------------------------------------
// gf2rk_core: row store and elimination sequencer
// Stores rows in the row RAM, then sweeps the RAM once per column: pivot
// search, swap and XOR elimination by read-modify-write. Pivot columns go
// to a second RAM that the kernel pass reads back.
// ----------------------------------------------------------------------------
module gf2rk_core #(
  parameter int MAX_ROWS = gf2rk_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gf2rk_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gf2rk_pkg::cfg_t             cfg,
  input  logic                        row_valid,
  output logic                        row_ready,
  input  logic [gf2rk_pkg::ROW_W-1:0] row_bits,
  input  logic                        last_row,
  output logic                        res_valid,
  output gf2rk_pkg::result_t          res,
  input  logic                        res_ready
);

  import gf2rk_pkg::*;

  localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int PIV_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IDX_W     = (ROW_CNT_W > RANK_W) ? ROW_CNT_W : RANK_W;

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_COL    = 6'b000010,
    S_SWEEP  = 6'b000100,
    S_COLEND = 6'b001000,
    S_KERN   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [ROW_CNT_W-1:0]   row_count, row_count_next;
  logic                   overflow_flag, overflow_flag_next;
  logic [RANK_W-1:0]      rank, rank_next;
  logic [COL_W-1:0]       col, col_next;
  logic [RANK_W-1:0]      ncols, ncols_next;
  logic                   mode, mode_next;
  logic [COL_W-1:0]       wstart, wstart_next;
  logic [ROW_W-1:0]       marks_left, marks_left_next;
  logic                   found_piv, found_piv_next;
  logic [ROW_W-1:0]       prow, prow_next;
  logic [ROW_W-1:0]       head, head_next;
  logic [IDX_W-1:0]       ptr, ptr_next;
  logic                   wrap, wrap_next;
  logic                   iss_active, iss_active_next;
  logic                   rd_vld, rd_vld_next;
  logic [IDX_W-1:0]       rd_idx, rd_idx_next;
  logic                   wit_found, wit_found_next;
  logic [COL_W-1:0]       wit_col, wit_col_next;
  logic [ROW_W-1:0]       kmask, kmask_next;
  result_t                res_q, res_next;

  // RAM ports
  logic                   row_we, row_re;
  logic [ROW_AW-1:0]      row_waddr, row_raddr;
  logic [ROW_W-1:0]       row_wdata, row_rdata;
  logic                   piv_we, piv_re;
  logic [PIV_AW-1:0]      piv_waddr, piv_raddr;
  logic [COL_W-1:0]       piv_wdata, piv_rdata;

  // helpers
  logic [RANK_W-1:0]      ncols_sat;
  logic [ROW_W-1:0]       col_mask;
  logic [IDX_W-1:0]       rank_idx, row_cnt_idx, ptr_inc;
  logic [RANK_W-1:0]      rank_inc;
  logic [ROW_W-1:0]       col_bit;
  logic                   is_head, last_col, free_here, in_search;
  logic [COL_W-1:0]       wit_sel;

  gf2rk_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  gf2rk_ram #(.WIDTH(COL_W), .DEPTH(MAX_COLS)) u_pivots (
    .clk   (clk),
    .we    (piv_we),
    .waddr (piv_waddr),
    .wdata (piv_wdata),
    .re    (piv_re),
    .raddr (piv_raddr),
    .rdata (piv_rdata)
  );

  assign ncols_sat = (cfg.column_count > RANK_W'(MAX_COLS)) ? RANK_W'(MAX_COLS)
                                                            : cfg.column_count;
  assign col_mask  = (ncols_sat >= RANK_W'(ROW_W)) ? '1
                   : ((ROW_W'(1) << ncols_sat) - ROW_W'(1));
  assign rank_idx    = IDX_W'(rank);
  assign row_cnt_idx = IDX_W'(row_count);
  assign ptr_inc     = ptr + IDX_W'(1);
  assign rank_inc    = rank + RANK_W'(found_piv);
  assign col_bit     = ROW_W'(1) << col;
  assign is_head     = (rd_idx == rank_idx);
  assign in_search   = (rd_idx >= rank_idx);
  assign last_col    = ((RANK_W'(col) + RANK_W'(1)) == ncols);
  assign free_here   = !found_piv && !wit_found && (col >= wstart);
  assign wit_sel     = wit_found ? wit_col : col;

  assign row_ready = (state == S_LOAD);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    res          = res_q;
    res.overflow = overflow_flag;
  end

  always_comb begin
    state_next         = state;
    row_count_next     = row_count;
    overflow_flag_next = overflow_flag;
    rank_next          = rank;
    col_next           = col;
    ncols_next         = ncols;
    mode_next          = mode;
    wstart_next        = wstart;
    marks_left_next    = marks_left;
    found_piv_next     = found_piv;
    prow_next          = prow;
    head_next          = head;
    ptr_next           = ptr;
    wrap_next          = wrap;
    iss_active_next    = iss_active;
    rd_vld_next        = 1'b0;
    rd_idx_next        = rd_idx;
    wit_found_next     = wit_found;
    wit_col_next       = wit_col;
    kmask_next         = kmask;
    res_next           = res_q;
    row_we             = 1'b0;
    row_waddr          = row_count[ROW_AW-1:0];
    row_wdata          = row_bits;
    row_re             = 1'b0;
    row_raddr          = ptr[ROW_AW-1:0];
    piv_we             = 1'b0;
    piv_waddr          = rank_idx[PIV_AW-1:0];
    piv_wdata          = col;
    piv_re             = 1'b0;
    piv_raddr          = ptr[PIV_AW-1:0];

    unique case (state)
      S_LOAD: begin
        if (row_valid) begin
          if (row_count < ROW_CNT_W'(MAX_ROWS)) begin
            row_we         = 1'b1;
            row_count_next = row_count + ROW_CNT_W'(1);
          end else begin
            overflow_flag_next = 1'b1;
          end
          if (last_row) begin
            ncols_next      = ncols_sat;
            marks_left_next = cfg.block_end_mask & col_mask;
            mode_next       = cfg.mode;
            wstart_next     = cfg.witness_start;
            rank_next       = '0;
            col_next        = '0;
            wit_found_next  = 1'b0;
            if (ncols_sat == '0) begin
              // no columns at all: rank zero, single closing result
              res_next   = '{column_index: '0, rank_value: '0, found: 1'b0,
                             kernel_mask: '0, overflow: 1'b0, last: 1'b1};
              state_next = S_EMIT;
            end else begin
              state_next = S_COL;
            end
          end
        end
      end

      S_COL: begin
        found_piv_next = 1'b0;
        if (rank_idx >= row_cnt_idx) begin
          // every row already holds a pivot
          state_next = S_COLEND;
        end else begin
          ptr_next        = rank_idx;
          wrap_next       = 1'b0;
          iss_active_next = 1'b1;
          state_next      = S_SWEEP;
        end
      end

      S_SWEEP: begin
        // issue side: rank..rows-1, then 0..rank-1 for full reduction
        if (iss_active) begin
          row_re      = 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = ptr;
          if (!wrap && ptr_inc == row_cnt_idx) begin
            if (mode == MODE_WITNESS && rank != '0) begin
              wrap_next = 1'b1;
              ptr_next  = '0;
            end else begin
              iss_active_next = 1'b0;
            end
          end else if (wrap && ptr_inc == rank_idx) begin
            iss_active_next = 1'b0;
          end else begin
            ptr_next = ptr_inc;
          end
        end
        // data side: one row back from the RAM each cycle
        if (rd_vld) begin
          row_waddr = rd_idx[ROW_AW-1:0];
          if (!found_piv) begin
            if (is_head) begin
              head_next = row_rdata;
            end
            // rows above rank already carry pivots and never serve as one
            if (row_rdata[col] && in_search) begin
              // pivot: park the head row in its place, pivot goes to rank
              found_piv_next = 1'b1;
              prow_next      = row_rdata;
              row_we         = 1'b1;
              row_wdata      = is_head ? row_rdata : head;
            end
          end else if (row_rdata[col]) begin
            row_we    = 1'b1;
            row_wdata = row_rdata ^ prow;
          end
        end
        if (!iss_active && !rd_vld) begin
          state_next = S_COLEND;
        end
      end

      S_COLEND: begin
        if (found_piv) begin
          row_we    = 1'b1;
          row_waddr = rank_idx[ROW_AW-1:0];
          row_wdata = prow;
          piv_we    = 1'b1;
        end
        rank_next = rank_inc;
        if (mode == MODE_PROFILE) begin
          marks_left_next = marks_left & ~col_bit;
          if (marks_left[col] || last_col) begin
            res_next   = '{column_index: col, rank_value: rank_inc, found: 1'b0,
                           kernel_mask: '0, overflow: 1'b0,
                           last: ((marks_left & ~col_bit) == '0)};
            state_next = S_EMIT;
          end else begin
            col_next   = col + COL_W'(1);
            state_next = S_COL;
          end
        end else begin
          if (free_here) begin
            wit_found_next = 1'b1;
            wit_col_next   = col;
          end
          if (last_col) begin
            if (wit_found || free_here) begin
              wit_col_next    = wit_sel;
              kmask_next      = ROW_W'(1) << wit_sel;
              ptr_next        = '0;
              iss_active_next = (rank_inc != '0);
              state_next      = S_KERN;
            end else begin
              res_next   = '{column_index: '0, rank_value: rank_inc, found: 1'b0,
                             kernel_mask: '0, overflow: 1'b0, last: 1'b1};
              state_next = S_EMIT;
            end
          end else begin
            col_next   = col + COL_W'(1);
            state_next = S_COL;
          end
        end
      end

      S_KERN: begin
        // walk the reduced pivot rows; each one holding the witness column
        // adds its pivot column to the kernel vector
        if (iss_active) begin
          row_re      = 1'b1;
          piv_re      = 1'b1;
          rd_vld_next = 1'b1;
          if (ptr_inc == rank_idx) begin
            iss_active_next = 1'b0;
          end else begin
            ptr_next = ptr_inc;
          end
        end
        if (rd_vld && row_rdata[wit_col]) begin
          kmask_next = kmask | (ROW_W'(1) << piv_rdata);
        end
        if (!iss_active && !rd_vld) begin
          res_next   = '{column_index: wit_col, rank_value: rank, found: 1'b1,
                         kernel_mask: kmask, overflow: 1'b0, last: 1'b1};
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res_q.last) begin
            row_count_next     = '0;
            overflow_flag_next = 1'b0;
            rank_next          = '0;
            state_next         = S_LOAD;
          end else begin
            col_next   = col + COL_W'(1);
            state_next = S_COL;
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      row_count     <= '0;
      overflow_flag <= 1'b0;
      rank          <= '0;
      iss_active    <= 1'b0;
      rd_vld        <= 1'b0;
      found_piv     <= 1'b0;
      wit_found     <= 1'b0;
    end else begin
      state         <= state_next;
      row_count     <= row_count_next;
      overflow_flag <= overflow_flag_next;
      rank          <= rank_next;
      iss_active    <= iss_active_next;
      rd_vld        <= rd_vld_next;
      found_piv     <= found_piv_next;
      wit_found     <= wit_found_next;
    end
  end

  always_ff @(posedge clk) begin
    col        <= col_next;
    ncols      <= ncols_next;
    mode       <= mode_next;
    wstart     <= wstart_next;
    marks_left <= marks_left_next;
    prow       <= prow_next;
    head       <= head_next;
    ptr        <= ptr_next;
    wrap       <= wrap_next;
    rd_idx     <= rd_idx_next;
    wit_col    <= wit_col_next;
    kmask      <= kmask_next;
    res_q      <= res_next;
  end

endmodule

// ----- tb/tb_gf2_rank_and_kernel_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf2_rank_and_kernel_engine: self-checking bench for the GF(2) engine
// Streams bit-matrix rows into the engine and predicts every result word
// with an in-bench Gaussian elimination over the same configuration.
// Directed runs cover register extremes, profile and witness corner cases
// and row overflow. Back-pressure runs follow, then random matrices with
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_gf2_rank_and_kernel_engine;
  import gf2rk_pkg::*;

  localparam int ROW_CAP       = DEF_MAX_ROWS;
  localparam int COL_CAP       = DEF_MAX_COLS;
  localparam int RANDOM_ROWS   = 70;
  localparam int SETTLE_CYCLES = 32;    // let the engine clear its run state
  localparam int END_CYCLES    = 64;
  localparam int MAX_GAP       = 12;
  localparam int TIMEOUT_NS    = 16_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = CFG_MODE;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ROW_W-1:0]       s_axis_tdata = '0;     // [63:0] row_bits
  logic                   s_axis_tlast = 1'b0;   // last_row
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [5:0] column_index, [12:6] rank_value,
                                                 // [76:13] kernel_mask, [77] overflow
  logic [0:0]             m_axis_tuser;          // [0] found
  logic                   m_axis_tlast;          // last

  gf2_rank_and_kernel_engine i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Elimination predictor: own copy of the row store and the registers
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  row_store [ROW_CAP];
  int unsigned       stored_rows = 0;
  int unsigned       pivot_rank  = 0;
  logic [COL_W-1:0]  pivot_col [64];
  bit                rows_dropped = 1'b0;

  logic              cur_mode   = MODE_PROFILE;
  logic [RANK_W-1:0] cur_cols   = RST_COLUMN_COUNT;
  logic [ROW_W-1:0]  cur_marks  = '0;
  logic [COL_W-1:0]  cur_wstart = '0;

  result_t           pending_reports [$];
  int unsigned       error_count = 0;

  // stimulus knobs shared with the idling processes
  bit                in_no_idle  = 1'b0;
  bit                out_no_idle = 1'b0;
  int unsigned       out_hold_cycles = 0;
  logic [ROW_W-1:0]  basis_pool [5];

  function automatic void post_report(input int unsigned col, input int unsigned rnk,
                                      input bit fnd, input logic [ROW_W-1:0] kmask,
                                      input bit lst);
    result_t rep;
    rep.column_index = COL_W'(col);
    rep.rank_value   = RANK_W'(rnk);
    rep.found        = fnd;
    rep.kernel_mask  = kmask;
    rep.overflow     = rows_dropped;
    rep.last         = lst;
    pending_reports = {pending_reports, rep};
  endfunction

  // Pivot search in column c among the unused rows, swap the pivot row up and
  // clear the column below it (and above it too for Gauss-Jordan).
  function automatic bit reduce_column(input int unsigned c, input bit full);
    logic [ROW_W-1:0] colbit;
    logic [ROW_W-1:0] prow;
    int unsigned      p;
    colbit = 64'd1 << c;
    if (pivot_rank >= stored_rows) return 1'b0;
    p = pivot_rank;
    while (p < stored_rows && (row_store[p] & colbit) == '0) p++;
    if (p >= stored_rows) return 1'b0;
    prow = row_store[p];
    row_store[p] = row_store[pivot_rank];
    row_store[pivot_rank] = prow;
    for (int unsigned r = full ? 0 : pivot_rank + 1; r < stored_rows; r++) begin
      if (r != pivot_rank && (row_store[r] & colbit) != '0) row_store[r] ^= prow;
    end
    pivot_col[pivot_rank % 64] = COL_W'(c);
    pivot_rank++;
    return 1'b1;
  endfunction

  // Store one accepted row word; on the last row run the whole elimination
  // and queue every report that the run gives.
  function automatic void take_row(input logic [ROW_W-1:0] bits, input logic lst);
    int unsigned      ncols;
    int unsigned      f;
    int unsigned      nrep;
    logic [ROW_W-1:0] cmask;
    logic [ROW_W-1:0] marks;
    logic [ROW_W-1:0] pivmask;
    logic [ROW_W-1:0] kmask;
    bit               fnd;
    if (stored_rows < ROW_CAP) begin
      row_store[stored_rows] = bits;
      stored_rows++;
    end else begin
      rows_dropped = 1'b1;
    end
    if (!lst) return;

    ncols = (cur_cols < COL_CAP) ? cur_cols : COL_CAP;
    cmask = (ncols >= 64) ? '1 : ((64'd1 << ncols) - 64'd1);
    for (int unsigned r = 0; r < stored_rows; r++) row_store[r] &= cmask;
    pivot_rank = 0;

    if (cur_mode == MODE_PROFILE) begin
      marks = cur_marks & cmask;
      nrep = 0;
      for (int unsigned c = 0; c < ncols; c++) begin
        void'(reduce_column(c, 1'b0));
        if (marks[c]) begin
          post_report(c, pivot_rank, 1'b0, '0, (marks >> c) == 64'd1);
          nrep++;
        end
      end
      // no marked column: report the total rank once
      if (nrep == 0) post_report((ncols != 0) ? ncols - 1 : 0, pivot_rank, 1'b0, '0, 1'b1);
    end else begin
      pivmask = '0;
      kmask = '0;
      fnd = 1'b0;
      f = 0;
      for (int unsigned c = 0; c < ncols; c++) begin
        if (reduce_column(c, 1'b1)) pivmask[c] = 1'b1;
      end
      for (int unsigned c = cur_wstart; c < ncols && !fnd; c++) begin
        if (!pivmask[c]) begin
          fnd = 1'b1;
          f = c;
        end
      end
      // kernel vector: the free column plus each pivot column whose row holds it
      if (fnd) begin
        kmask = 64'd1 << f;
        for (int unsigned i = 0; i < pivot_rank && i < 64; i++) begin
          if (row_store[i][f]) kmask[pivot_col[i]] = 1'b1;
        end
      end
      post_report(fnd ? f : 0, pivot_rank, fnd, kmask, 1'b1);
    end

    stored_rows = 0;
    pivot_rank = 0;
    rows_dropped = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: feed accepted row words to the predictor, check result words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) take_row(s_axis_tdata, s_axis_tlast);
  end

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.column_index = m_axis_tdata[5:0];
      seen.rank_value   = m_axis_tdata[12:6];
      seen.kernel_mask  = m_axis_tdata[76:13];
      seen.overflow     = m_axis_tdata[77];
      seen.found        = m_axis_tuser[0];
      seen.last         = m_axis_tlast;
      if (pending_reports.size() == 0) begin
        $display("%0t ns: unexpected result word: expected none, got %0h/%0h/%0h",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("column_index", 64'(want.column_index), 64'(seen.column_index));
        compare_field("rank_value", 64'(want.rank_value), 64'(seen.rank_value));
        compare_field("found", 64'(want.found), 64'(seen.found));
        compare_field("kernel_mask", want.kernel_mask, seen.kernel_mask);
        compare_field("overflow", 64'(want.overflow), 64'(seen.overflow));
        compare_field("last", 64'(want.last), 64'(seen.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stall per word, plus a long hold when requested
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    forever begin
      if (out_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (out_hold_cycles) @(posedge clk);
        out_hold_cycles = 0;
      end
      stall = out_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_MODE:          cur_mode   = value[0];
      CFG_COLUMN_COUNT:  cur_cols   = value[RANK_W-1:0];
      CFG_BLOCK_END:     cur_marks  = value;
      CFG_WITNESS_START: cur_wstart = value[COL_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one row word after a random gap and hold it until accepted.
  task automatic send_row(input logic [ROW_W-1:0] bits, input logic lst);
    int unsigned gap;
    gap = in_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Drop valid, wait for every queued report, then let the run state clear.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mix of zero, all-ones, one-hot, random and dependent rows.
  function automatic logic [ROW_W-1:0] make_row();
    logic [ROW_W-1:0] acc;
    acc = '0;
    case ($urandom_range(0, 11))
      0:       acc = '0;
      1:       acc = '1;
      2:       acc = 64'd1 << $urandom_range(0, 63);
      3, 4:    acc = {$urandom, $urandom};
      default: begin
        foreach (basis_pool[i]) if ($urandom_range(0, 1)) acc ^= basis_pool[i];
      end
    endcase
    return acc;
  endfunction

  task automatic send_matrix(input int unsigned nrows);
    foreach (basis_pool[i]) begin
      basis_pool[i] = $urandom_range(0, 2) == 0 ? {$urandom, $urandom} & {$urandom, $urandom}
                                               : {$urandom, $urandom};
    end
    for (int unsigned i = 0; i < nrows; i++) send_row(make_row(), i == nrows - 1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: profile mode, 64 columns, no marks -> one total-rank word per run.
  task automatic test_reset_defaults();
    send_row(64'h0000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row(64'h0, 1'b1);               // single zero row
    wait_idle();
  endtask

  // Marks at columns 0, 3 and 7; marks and row bits above the column count
  // must be ignored.
  task automatic test_profile_marks();
    write_reg(CFG_MODE, CFG_W'(MODE_PROFILE));
    write_reg(CFG_COLUMN_COUNT, 64'd8);
    write_reg(CFG_BLOCK_END, 64'h8000_0000_0001_0089);
    send_row(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    send_row(64'h0000_0000_0000_0003, 1'b0);
    send_row(64'h0000_0000_0000_0001, 1'b0);
    send_row('1, 1'b0);
    send_row(64'h0000_0000_0000_0080, 1'b1);
    wait_idle();
  endtask

  // Gauss-Jordan witness: found column, late start, start beyond C, full rank.
  task automatic test_witness_kernel();
    write_reg(CFG_MODE, CFG_W'(MODE_WITNESS));
    write_reg(CFG_COLUMN_COUNT, 64'd16);
    write_reg(CFG_WITNESS_START, 64'd0);
    send_row(64'h0003, 1'b0);
    send_row(64'h0006, 1'b0);
    send_row(64'h0005, 1'b1);
    wait_idle();
    write_reg(CFG_WITNESS_START, 64'd15);
    send_row(64'h00FF, 1'b0);
    send_row(64'hFF00, 1'b1);
    wait_idle();
    write_reg(CFG_WITNESS_START, 64'd63);
    send_row(64'h1234_5678_9ABC_DEF0, 1'b0);
    send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
    wait_idle();
    write_reg(CFG_COLUMN_COUNT, 64'd4);
    write_reg(CFG_WITNESS_START, 64'd0);
    send_row(64'h1, 1'b0);
    send_row(64'h2, 1'b0);
    send_row(64'h4, 1'b0);
    send_row(64'h8, 1'b1);
    wait_idle();
  endtask

  // Zero columns, saturated columns, every column marked.
  task automatic test_column_count_limits();
    write_reg(CFG_MODE, CFG_W'(MODE_PROFILE));
    write_reg(CFG_COLUMN_COUNT, 64'd0);
    send_row('1, 1'b1);
    wait_idle();
    write_reg(CFG_MODE, CFG_W'(MODE_WITNESS));
    send_row('1, 1'b1);
    wait_idle();
    write_reg(CFG_MODE, CFG_W'(MODE_PROFILE));
    write_reg(CFG_COLUMN_COUNT, 64'd127);
    write_reg(CFG_BLOCK_END, '1);
    send_row({$urandom, $urandom}, 1'b0);
    send_row({$urandom, $urandom}, 1'b1);
    wait_idle();
    write_reg(CFG_MODE, CFG_W'(MODE_WITNESS));
    write_reg(CFG_WITNESS_START, 64'd63);
    send_row('1, 1'b1);
    wait_idle();
  endtask

  // Two rows past capacity, the dropped last row still starts the run; the
  // next run must come back with overflow clear.
  task automatic test_row_overflow();
    write_reg(CFG_MODE, CFG_W'(MODE_PROFILE));
    write_reg(CFG_COLUMN_COUNT, 64'd12);
    write_reg(CFG_BLOCK_END, 64'h821);
    in_no_idle = 1'b1;
    send_matrix(ROW_CAP + 2);
    in_no_idle = 1'b0;
    send_matrix(2);
    wait_idle();
  endtask

  // Hold the receiver for a long stretch while rows keep coming so the
  // engine backs up into its input; then pause the sender until drained.
  task automatic test_backpressure();
    write_reg(CFG_COLUMN_COUNT, 64'd64);
    write_reg(CFG_BLOCK_END, '1);
    in_no_idle = 1'b1;
    out_hold_cycles = 400;
    send_matrix(8);
    send_matrix(6);
    in_no_idle = 1'b0;
    wait_idle();
    write_reg(CFG_MODE, CFG_W'(MODE_WITNESS));
    write_reg(CFG_WITNESS_START, 64'd0);
    send_matrix(5);
    wait_idle();
    send_matrix(5);
    wait_idle();
  endtask

  // Random phases: new registers, then one to three random matrices.
  task automatic test_random_matrices();
    int unsigned rows_sent;
    int unsigned nrows;
    rows_sent = 0;
    while (rows_sent < RANDOM_ROWS) begin
      if ($urandom_range(0, 1)) write_reg(CFG_MODE, CFG_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_COLUMN_COUNT, 64'd0);
          1:       write_reg(CFG_COLUMN_COUNT, 64'd64);
          2:       write_reg(CFG_COLUMN_COUNT, CFG_W'($urandom_range(65, 127)));
          3, 4, 5: write_reg(CFG_COLUMN_COUNT, CFG_W'($urandom_range(1, 16)));
          default: write_reg(CFG_COLUMN_COUNT, CFG_W'($urandom_range(1, 64)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_BLOCK_END, '0);
          1:       write_reg(CFG_BLOCK_END, '1);
          2:       write_reg(CFG_BLOCK_END, 64'd1 << $urandom_range(0, 63));
          3:       write_reg(CFG_BLOCK_END, {$urandom, $urandom} & {$urandom, $urandom});
          default: write_reg(CFG_BLOCK_END, {$urandom, $urandom});
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_WITNESS_START, 64'd0);
          1:       write_reg(CFG_WITNESS_START, 64'd63);
          default: write_reg(CFG_WITNESS_START, CFG_W'($urandom_range(0, 15)));
        endcase
      end
      // some phases run without idling on one side or the other
      in_no_idle  = ($urandom_range(0, 4) == 0);
      out_no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 19))
          0:             nrows = $urandom_range(30, 70);
          1, 2, 3, 4, 5: nrows = $urandom_range(1, 3);
          default:       nrows = $urandom_range(2, 12);
        endcase
        send_matrix(nrows);
        rows_sent += nrows;
      end
      wait_idle();
    end
    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence and end of run
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_profile_marks();
    test_witness_kernel();
    test_column_count_limits();
    test_row_overflow();
    test_backpressure();
    test_random_matrices();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gf2rk_pkg.sv
rtl/gf2rk_ram.sv
rtl/gf2rk_out.sv
rtl/gf2rk_core.sv
rtl/gf2_rank_and_kernel_engine.sv
tb/tb_gf2_rank_and_kernel_engine.sv
